### rtl/trtu_pkg.sv
// Package for the trigger record timestamp unwrap unit.
// Holds field widths, register reset values, register indexes and the record struct.
// No dependencies.
`timescale 1ns / 1ps

package trtu_pkg;

  // Default widths of the two wrap counters
  localparam int unsigned TsWrapBitsDef = 8;
  localparam int unsigned IdWrapBitsDef = 16;

  // Field widths of one record
  localparam int unsigned RawTsW   = 40;
  localparam int unsigned TrigW    = 16;
  localparam int unsigned PeriodW  = 24;
  localparam int unsigned MarginW  = 16;
  localparam int unsigned IdOutW   = 32;
  localparam int unsigned TicksOutW = 48;
  localparam int unsigned TimeW    = 64;

  // Register reset values
  localparam logic [PeriodW-1:0] TickPeriodRst = 24'd492752;
  localparam logic [MarginW-1:0] IdMarginRst   = 16'd500;

  // Register indexes (word address bit)
  localparam logic RegTickPeriod = 1'b0;
  localparam logic RegIdMargin   = 1'b1;

  // Position of the last byte of an 8-byte record
  localparam logic [2:0] LastByte = 3'd7;

  // Result fields that travel alongside the time computation
  typedef struct packed {
    logic [IdOutW-1:0]    trigger_id;
    logic [TicksOutW-1:0] ticks;
    logic                 wrap_sat;
  } rec_t;

endpackage

### rtl/trtu_scale.sv
// Tick-to-time scaling pipeline of the timestamp unwrap unit.
// Two partial products, then saturating add into the output register.
// Depends on trtu_pkg.
`timescale 1ns / 1ps

module trtu_scale #(
  parameter int unsigned TS_WRAP_BITS = trtu_pkg::TsWrapBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  trtu_pkg::rec_t               in_rec_i,
  input  logic [TS_WRAP_BITS+39:0]     in_ticks_i,
  input  logic [trtu_pkg::PeriodW-1:0] period_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output trtu_pkg::rec_t               out_rec_o,
  output logic [trtu_pkg::TimeW-1:0]   out_time_o
);

  localparam int unsigned TickW = TS_WRAP_BITS + trtu_pkg::RawTsW;
  localparam int unsigned HinW  = TickW - 32;
  localparam int unsigned HiW   = HinW + trtu_pkg::PeriodW;
  localparam int unsigned LoW   = 32 + trtu_pkg::PeriodW;

  logic           s2_valid_q;
  trtu_pkg::rec_t s2_rec_q;
  logic [HiW-1:0] s2_hi_q;
  logic [LoW-1:0] s2_lo_q;

  logic                       out_valid_q;
  trtu_pkg::rec_t             out_rec_q;
  logic [trtu_pkg::TimeW-1:0] out_time_q;
  logic [trtu_pkg::TimeW-1:0] time_d;

  logic        out_ready;
  logic [63:0] hi64;
  logic        hi_over;
  logic [64:0] sum;

  assign out_ready  = !out_valid_q || out_ready_i;
  assign in_ready_o = !s2_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s2_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s2_rec_q <= in_rec_i;
      s2_hi_q  <= in_ticks_i[TickW-1:32] * period_i;
      s2_lo_q  <= in_ticks_i[31:0] * period_i;
    end
  end

  always_comb begin
    hi64    = 64'(s2_hi_q);
    hi_over = |hi64[63:40];
    sum     = {1'b0, hi64[39:0], 24'd0} + {17'd0, s2_lo_q[LoW-1:8]};
    time_d  = (hi_over || sum[64]) ? '1 : sum[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s2_valid_q) begin
      out_rec_q  <= s2_rec_q;
      out_time_q <= time_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;
  assign out_time_o  = out_time_q;

endmodule

### rtl/trigger_record_timestamp_unwrap_unit.sv
// Top level of the trigger record timestamp unwrap unit.
// Assembles records, unwraps counters, holds registers; uses trtu_pkg and trtu_scale.
`timescale 1ns / 1ps

// Usage:
// - Slave stream: one byte per transfer. Eight bytes form a little-endian record:
//   tag byte (ignored), 16-bit trigger number, 40-bit tick timestamp.
// - Master stream: one transfer per completed record carrying the extended
//   trigger id, the extended tick count and the time in 1/256 ns (tdata), and
//   the wrap saturation flag (tuser).
// - APB port: tick period (Q8.16 ns per tick) at 0x0, trigger wrap margin at 0x4.
//   Write only while the stream is idle; pready is always high.
// - Throughput: one byte per cycle. The record-assembly register, the
//   stage-1 result register, the partial product register and the output
//   register form the pipeline, so every byte, including a record's last one,
//   can be taken each cycle while the receiver keeps up.
// - Result path: the edge that takes the last byte of a record loads the
//   unwrap state and the stage-1 result register; the product stage and
//   then the add into the output register follow, and tvalid rises with it.
// - Stall: the output register holds its transfer; the two stages behind it
//   keep filling, and tready drops only for a last byte that finds them full.
//   Bytes 0..6 of a record are always accepted.
// - Reset: byte position, wrap counters and previous values clear; registers
//   take their reset values; no result is pending.

module trigger_record_timestamp_unwrap_unit #(
  parameter int unsigned TS_WRAP_BITS = trtu_pkg::TsWrapBitsDef,
  parameter int unsigned ID_WRAP_BITS = trtu_pkg::IdWrapBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream: [7:0] data_byte
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  // master stream: [31:0] trigger_id, [79:32] timestamp_ticks, [143:80] time_fine_ns
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,
  // tuser: [0] wrap_saturated
  output logic [0:0]   m_axis_tuser,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned TickW = TS_WRAP_BITS + trtu_pkg::RawTsW;
  localparam logic [TS_WRAP_BITS-1:0] TsWrapMax = '1;
  localparam logic [ID_WRAP_BITS-1:0] IdWrapMax = '1;

  // Configuration registers
  logic [trtu_pkg::PeriodW-1:0] period_q;
  logic [trtu_pkg::MarginW-1:0] margin_q;
  logic                         cfg_wr;

  // Record assembly and unwrap state
  logic [2:0]                 pos_q;
  logic [55:0]                rec_q;
  logic [trtu_pkg::RawTsW-1:0] prev_ts_q;
  logic [TS_WRAP_BITS-1:0]    ts_wraps_q, ts_wraps_d;
  logic [trtu_pkg::TrigW-1:0] prev_trig_q;
  logic [ID_WRAP_BITS-1:0]    id_wraps_q, id_wraps_d;

  // Stage 1 result register
  logic           s1_valid_q;
  trtu_pkg::rec_t s1_rec_q, s1_rec_d;
  logic [TickW-1:0] s1_ticks_q, s1_ticks_d;

  logic                        s1_ready;
  logic                        scale_ready;
  logic                        in_xfer;
  logic                        last_xfer;
  logic [trtu_pkg::RawTsW-1:0] ts_raw;
  logic [trtu_pkg::TrigW-1:0]  trig_raw;

  trtu_pkg::rec_t             out_rec;
  logic [trtu_pkg::TimeW-1:0] out_time;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= trtu_pkg::TickPeriodRst;
      margin_q <= trtu_pkg::IdMarginRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        trtu_pkg::RegTickPeriod: period_q <= pwdata[trtu_pkg::PeriodW-1:0];
        trtu_pkg::RegIdMargin:   margin_q <= pwdata[trtu_pkg::MarginW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      trtu_pkg::RegTickPeriod: prdata = 32'(period_q);
      trtu_pkg::RegIdMargin:   prdata = 32'(margin_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------- input handshake ----------------
  // Bytes 0..6 only shift into the assembly register; the last byte needs room
  // in stage 1.
  assign s1_ready      = !s1_valid_q || scale_ready;
  assign s_axis_tready = (pos_q != trtu_pkg::LastByte) || s1_ready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign last_xfer     = in_xfer && (pos_q == trtu_pkg::LastByte);

  // ---------------- unwrap logic ----------------
  assign trig_raw = rec_q[23:8];
  assign ts_raw   = {s_axis_tdata, rec_q[55:24]};

  always_comb begin
    ts_wraps_d = ts_wraps_q;
    if ((ts_raw < prev_ts_q) && (ts_wraps_q != TsWrapMax)) begin
      ts_wraps_d = ts_wraps_q + 1'b1;
    end
    // Count a trigger wrap only on a drop larger than the margin
    id_wraps_d = id_wraps_q;
    if ((prev_trig_q >= margin_q) && (trig_raw < (prev_trig_q - margin_q)) &&
        (id_wraps_q != IdWrapMax)) begin
      id_wraps_d = id_wraps_q + 1'b1;
    end

    s1_ticks_d          = {ts_wraps_d, ts_raw};
    s1_rec_d.trigger_id = {16'(id_wraps_d), trig_raw};
    s1_rec_d.ticks      = 48'(s1_ticks_d);
    s1_rec_d.wrap_sat   = (ts_wraps_d == TsWrapMax) || (id_wraps_d == IdWrapMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      rec_q       <= '0;
      prev_ts_q   <= '0;
      ts_wraps_q  <= '0;
      prev_trig_q <= '0;
      id_wraps_q  <= '0;
    end else if (in_xfer) begin
      if (last_xfer) begin
        pos_q       <= '0;
        rec_q       <= '0;
        prev_ts_q   <= ts_raw;
        ts_wraps_q  <= ts_wraps_d;
        prev_trig_q <= trig_raw;
        id_wraps_q  <= id_wraps_d;
      end else begin
        // Drop the byte into its slot and advance
        rec_q[8*pos_q +: 8] <= s_axis_tdata;
        pos_q               <= pos_q + 3'd1;
      end
    end
  end

  // ---------------- stage 1 register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= last_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_xfer) begin
      s1_rec_q   <= s1_rec_d;
      s1_ticks_q <= s1_ticks_d;
    end
  end

  // ---------------- time scaling and output register ----------------
  trtu_scale #(
    .TS_WRAP_BITS(TS_WRAP_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (scale_ready),
    .in_rec_i    (s1_rec_q),
    .in_ticks_i  (s1_ticks_q),
    .period_i    (period_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rec_o   (out_rec),
    .out_time_o  (out_time)
  );

  assign m_axis_tdata = {out_time, out_rec.ticks, out_rec.trigger_id};
  assign m_axis_tuser = out_rec.wrap_sat;

endmodule
